// ----- src/ppp_pkg.sv -----
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared constants, register codes and pipeline control types for the
// pinhole perspective projection block.
// ----------------------------------------------------------------------------
package ppp_pkg;

    // Default coordinate word and fraction widths (signed Q16.16)
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Quotient bits resolved per divider pipeline stage
    localparam int DIV_STEPS_PER_STAGE = 2;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_FOCAL_X     = 2'd0,
        CFG_FOCAL_Y     = 2'd1,
        CFG_PRINCIPAL_X = 2'd2,
        CFG_PRINCIPAL_Y = 2'd3
    } cfg_reg_t;

    // Control flags that travel down the pipeline beside the arithmetic
    typedef struct packed {
        logic valid;   // stage holds a request
        logic front;   // point lies in front of the camera (x > 0)
        logic neg_u;   // y was negative
        logic neg_v;   // z was negative
    } ctrl_t;

endpackage

// ----- src/ppp_div_pipe.sv -----
// ----------------------------------------------------------------------------
// ppp_div_pipe
// Pipelined restoring divider: 2W-bit dividend by a positive (W-1)-bit
// divisor, giving the low W+1 quotient bits and a flag for a larger quotient.
// ----------------------------------------------------------------------------
module ppp_div_pipe
    import ppp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic [2*COORD_WIDTH-1:0]   dividend,
    input  logic [COORD_WIDTH-2:0]     divisor,
    output logic [COORD_WIDTH:0]       quotient,
    output logic                       overflow
);

    localparam int STEPS      = COORD_WIDTH + 1;
    localparam int NUM_STAGES = (COORD_WIDTH + DIV_STEPS_PER_STAGE) / DIV_STEPS_PER_STAGE;

    logic [COORD_WIDTH-2:0] dividend_hi;

    logic [COORD_WIDTH-1:0] rem_reg [0:NUM_STAGES];
    logic [COORD_WIDTH:0]   dq_reg  [0:NUM_STAGES];
    logic [COORD_WIDTH-2:0] dvs_reg [0:NUM_STAGES];
    logic                   ovf_reg [0:NUM_STAGES];

    // Quotient needs more than W+1 bits exactly when the upper part of the
    // dividend already reaches the divisor; otherwise it is the first remainder.
    assign dividend_hi = dividend[2*COORD_WIDTH-1:COORD_WIDTH+1];

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= {1'b0, dividend_hi};
        dq_reg[0]  <= dividend[COORD_WIDTH:0];
        dvs_reg[0] <= divisor;
        ovf_reg[0] <= (dividend_hi >= divisor);
    end

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        logic [COORD_WIDTH-1:0] rem_next;
        logic [COORD_WIDTH-1:0] trial;
        logic [COORD_WIDTH:0]   dq_next;
        logic                   qbit;

        // Shift in dividend bits from the top, quotient bits in at the bottom
        always_comb
        begin
            rem_next = rem_reg[s];
            dq_next  = dq_reg[s];
            trial    = '0;
            qbit     = 1'b0;
            for (int k = 0; k < DIV_STEPS_PER_STAGE; k++)
            begin
                if (s * DIV_STEPS_PER_STAGE + k < STEPS)
                begin
                    trial    = {rem_next[COORD_WIDTH-2:0], dq_next[COORD_WIDTH]};
                    qbit     = (trial >= {1'b0, dvs_reg[s]});
                    rem_next = qbit ? (trial - {1'b0, dvs_reg[s]}) : trial;
                    dq_next  = {dq_next[COORD_WIDTH-1:0], qbit};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= rem_next;
            dq_reg[s+1]  <= dq_next;
            dvs_reg[s+1] <= dvs_reg[s];
            ovf_reg[s+1] <= ovf_reg[s];
        end
    end

    assign quotient = dq_reg[NUM_STAGES];
    assign overflow = ovf_reg[NUM_STAGES];

endmodule

// ----- src/pinhole_perspective_projection.sv -----
// ----------------------------------------------------------------------------
// pinhole_perspective_projection
// Projects camera-frame points (x forward, y left, z up) onto the image
// plane of a pinhole camera: u = px - fx*y/x, v = py - fy*z/x.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive pos_x/pos_y/pos_z and raise start; the request
//   is taken at a rising edge with start high and busy low. busy is high
//   only during reset and the first cycle after it; otherwise a new request
//   may be issued in every cycle.
//   Result channel: done marks one cycle holding valid_res, img_u, img_v,
//   depth_out and saturated. The receiver cannot hold results off, so the
//   pipeline never stalls and advances every cycle.
//   Pipeline: one multiply stage, one divider setup stage, NUM_DIV_STAGES
//   divider stages resolving up to two quotient bits each, and the output
//   register. Throughput is one point per cycle.
//   Configuration: write focal_x, focal_y, principal_x, principal_y through
//   cfg_valid/cfg_ready/cfg_index/cfg_data while no request is in flight.
//   Reset: focal lengths return to 1.0, the principal point to zero, all
//   in-flight requests are dropped and done goes low.
// ----------------------------------------------------------------------------
module pinhole_perspective_projection
    import ppp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    // request channel
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,

    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,

    // result channel
    output logic                          done,
    output logic                          valid_res,
    output logic signed [COORD_WIDTH-1:0] img_u,
    output logic signed [COORD_WIDTH-1:0] img_v,
    output logic [COORD_WIDTH-2:0]        depth_out,
    output logic                          saturated
);

    localparam int PW             = 2 * COORD_WIDTH;
    localparam int NUM_DIV_STAGES = (COORD_WIDTH + DIV_STEPS_PER_STAGE) / DIV_STEPS_PER_STAGE;
    // Sideband delay: multiply stage plus the divider's setup and bit stages
    localparam int SIDE_DEPTH     = NUM_DIV_STAGES + 1;

    localparam logic [COORD_WIDTH-1:0] FOCAL_RESET = COORD_WIDTH'(64'd1 << FRAC_BITS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                   busy_reg;
    logic [COORD_WIDTH-1:0] focal_x_reg;
    logic [COORD_WIDTH-1:0] focal_y_reg;
    logic [COORD_WIDTH-1:0] principal_x_reg;
    logic [COORD_WIDTH-1:0] principal_y_reg;

    // Hold off both channels until the first cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= 1'b0;
    end

    assign busy      = busy_reg;
    assign cfg_ready = ~busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg     <= FOCAL_RESET;
            focal_y_reg     <= FOCAL_RESET;
            principal_x_reg <= '0;
            principal_y_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FOCAL_X:     focal_x_reg     <= cfg_data;
                CFG_FOCAL_Y:     focal_y_reg     <= cfg_data;
                CFG_PRINCIPAL_X: principal_x_reg <= cfg_data;
                CFG_PRINCIPAL_Y: principal_y_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: sign split and focal multiply
    // ------------------------------------------------------------------
    logic                   accept;
    logic [COORD_WIDTH-1:0] mag_y;
    logic [COORD_WIDTH-1:0] mag_z;
    logic [PW-1:0]          prod_u_next;
    logic [PW-1:0]          prod_v_next;
    ctrl_t                  ctrl_next;

    logic [PW-1:0]          prod_u_reg;
    logic [PW-1:0]          prod_v_reg;
    logic [COORD_WIDTH-2:0] divisor_reg;

    assign accept = start && !busy_reg;

    // Magnitudes: the most negative value maps onto 2^(W-1) as unsigned
    assign mag_y = pos_y[COORD_WIDTH-1] ? (~pos_y + COORD_WIDTH'(1)) : pos_y;
    assign mag_z = pos_z[COORD_WIDTH-1] ? (~pos_z + COORD_WIDTH'(1)) : pos_z;

    // Exact products, W x W unsigned into 2W bits
    assign prod_u_next = PW'(focal_x_reg) * PW'(mag_y);
    assign prod_v_next = PW'(focal_y_reg) * PW'(mag_z);

    always_comb
    begin
        ctrl_next.valid = accept;
        ctrl_next.front = !pos_x[COORD_WIDTH-1] && (pos_x != '0);
        ctrl_next.neg_u = pos_y[COORD_WIDTH-1];
        ctrl_next.neg_v = pos_z[COORD_WIDTH-1];
    end

    always_ff @(posedge clk)
    begin
        prod_u_reg  <= prod_u_next;
        prod_v_reg  <= prod_v_next;
        divisor_reg <= pos_x[COORD_WIDTH-2:0];
    end

    // ------------------------------------------------------------------
    // Sideband delay line, aligned with the divider outputs
    // ------------------------------------------------------------------
    ctrl_t                  ctrl_reg  [0:SIDE_DEPTH];
    logic [COORD_WIDTH-2:0] depth_reg [0:SIDE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= SIDE_DEPTH; i++)
                ctrl_reg[i] <= '0;
        end
        else
        begin
            ctrl_reg[0] <= ctrl_next;
            for (int i = 1; i <= SIDE_DEPTH; i++)
                ctrl_reg[i] <= ctrl_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        depth_reg[0] <= pos_x[COORD_WIDTH-2:0];
        for (int i = 1; i <= SIDE_DEPTH; i++)
            depth_reg[i] <= depth_reg[i-1];
    end

    // ------------------------------------------------------------------
    // Divider pipelines: |f*c| / x for each image axis. Points behind the
    // camera run through too; their quotients are dropped at the output.
    // ------------------------------------------------------------------
    logic [COORD_WIDTH:0] quot_u;
    logic [COORD_WIDTH:0] quot_v;
    logic                 ovf_u;
    logic                 ovf_v;

    ppp_div_pipe #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_div_u (
        .clk      (clk),
        .dividend (prod_u_reg),
        .divisor  (divisor_reg),
        .quotient (quot_u),
        .overflow (ovf_u)
    );

    ppp_div_pipe #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_div_v (
        .clk      (clk),
        .dividend (prod_v_reg),
        .divisor  (divisor_reg),
        .quotient (quot_v),
        .overflow (ovf_v)
    );

    // ------------------------------------------------------------------
    // Output stage: offset by the principal point and saturate.
    // Returns {saturated, value}.
    // ------------------------------------------------------------------
    function automatic logic [COORD_WIDTH:0] finish_axis(
        input logic [COORD_WIDTH:0]   q,
        input logic                   ovf,
        input logic                   neg,
        input logic [COORD_WIDTH-1:0] p
    );
        logic [COORD_WIDTH+2:0] p_ext;
        logic [COORD_WIDTH+2:0] q_ext;
        logic [COORD_WIDTH+2:0] r;
        logic [COORD_WIDTH-1:0] smax;
        logic [COORD_WIDTH-1:0] smin;
        logic [COORD_WIDTH:0]   res;
        begin
            smax  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            smin  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            p_ext = {{3{p[COORD_WIDTH-1]}}, p};
            q_ext = {2'b00, q};
            // Subtracting f*c/x: a negative c adds the magnitude quotient
            r     = neg ? (p_ext + q_ext) : (p_ext - q_ext);
            if (ovf)
                res = {1'b1, (neg ? smax : smin)};
            else if (!r[COORD_WIDTH+2] && (r[COORD_WIDTH+1:COORD_WIDTH-1] != 3'b000))
                res = {1'b1, smax};
            else if (r[COORD_WIDTH+2] && (r[COORD_WIDTH+1:COORD_WIDTH-1] != 3'b111))
                res = {1'b1, smin};
            else
                res = {1'b0, r[COORD_WIDTH-1:0]};
            return res;
        end
    endfunction

    ctrl_t                  ctrl_out;
    logic [COORD_WIDTH:0]   axis_u;
    logic [COORD_WIDTH:0]   axis_v;

    logic                   done_next;
    logic                   valid_res_next;
    logic [COORD_WIDTH-1:0] img_u_next;
    logic [COORD_WIDTH-1:0] img_v_next;
    logic [COORD_WIDTH-2:0] depth_next;
    logic                   saturated_next;

    logic                   done_reg;
    logic                   valid_res_reg;
    logic [COORD_WIDTH-1:0] img_u_reg;
    logic [COORD_WIDTH-1:0] img_v_reg;
    logic [COORD_WIDTH-2:0] depth_out_reg;
    logic                   saturated_reg;

    assign ctrl_out = ctrl_reg[SIDE_DEPTH];
    assign axis_u   = finish_axis(quot_u, ovf_u, ctrl_out.neg_u, principal_x_reg);
    assign axis_v   = finish_axis(quot_v, ovf_v, ctrl_out.neg_v, principal_y_reg);

    // Zero every field for a point on or behind the camera plane
    always_comb
    begin
        done_next      = ctrl_out.valid;
        valid_res_next = ctrl_out.front;
        img_u_next     = ctrl_out.front ? axis_u[COORD_WIDTH-1:0] : '0;
        img_v_next     = ctrl_out.front ? axis_v[COORD_WIDTH-1:0] : '0;
        depth_next     = ctrl_out.front ? depth_reg[SIDE_DEPTH] : '0;
        saturated_next = ctrl_out.front && (axis_u[COORD_WIDTH] || axis_v[COORD_WIDTH]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        valid_res_reg <= valid_res_next;
        img_u_reg     <= img_u_next;
        img_v_reg     <= img_v_next;
        depth_out_reg <= depth_next;
        saturated_reg <= saturated_next;
    end

    assign done      = done_reg;
    assign valid_res = valid_res_reg;
    assign img_u     = img_u_reg;
    assign img_v     = img_v_reg;
    assign depth_out = depth_out_reg;
    assign saturated = saturated_reg;

endmodule

// ----- src/ppp_checker.sv -----
// ----------------------------------------------------------------------------
// ppp_checker
// Port-level checks for the projection block: fixed latency, zeroed fields
// for points behind the camera, and flag consistency.
// ----------------------------------------------------------------------------
module ppp_checker
    import ppp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic                          valid_res,
    input logic signed [COORD_WIDTH-1:0] img_u,
    input logic signed [COORD_WIDTH-1:0] img_v,
    input logic [COORD_WIDTH-2:0]        depth_out,
    input logic                          saturated
);

    localparam int NUM_DIV_STAGES = (COORD_WIDTH + DIV_STEPS_PER_STAGE) / DIV_STEPS_PER_STAGE;
    localparam int LATENCY        = NUM_DIV_STAGES + 3;

    // Every accepted request gives a result a fixed number of cycles later
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request did not produce a result on time");

    // No result without a matching request
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching request");

    // Points behind the camera give all-zero fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |->
            (img_u == '0) && (img_v == '0) && (depth_out == '0) && !saturated)
        else $error("invalid point with nonzero fields");

    // A projected point has a positive depth
    a_depth_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && valid_res) |-> (depth_out != '0))
        else $error("valid point with zero depth");

endmodule

bind pinhole_perspective_projection ppp_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_ppp_checker (.*);
